/* rtl/core/fcpa_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the fixed chunk pool allocator.
// No dependencies.
package fcpa_pkg;

    localparam int POOL_DEPTH_DEF = 1024;

    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int BYTES_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [COUNT_W-1:0] RST_CHUNK_COUNT  = COUNT_W'(1024);
    localparam logic [BYTES_W-1:0] RST_CHUNK_BYTES  = BYTES_W'(64);
    localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = CFG_IDX_W'(2);

    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_FULL  = STATUS_W'(2);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

/* rtl/core/fcpa_queue_ram.sv */
`timescale 1ns / 1ps
// Free-list queue storage: one write port, one read port, registered read.
// Depends on fcpa_pkg.
module fcpa_queue_ram
    import fcpa_pkg::*;
#(
    parameter int DEPTH = POOL_DEPTH_DEF,
    parameter int WIDTH = ADDR_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/fixed_chunk_pool_allocator_core.sv */
`timescale 1ns / 1ps
// Fixed chunk pool allocator top level: fresh-address generator, FIFO free list
// control and result register. Depends on fcpa_pkg and fcpa_queue_ram.
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+-------------------------------------
//  in      | in        | i_in_valid/o_in_stall | i_op, i_chunk_address
//  out     | out       | o_out_valid/i_out_stall| o_status, o_granted_address, o_free_total
//  cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Fresh allocations, frees and empty/full results go straight to the result register.
// An allocation served from the free queue waits in S_READ for the registered queue RAM read.
// Reset is synchronous; no clearing pass, queue entries are read only after a write.
// A stalled output holds its result; the next beat is taken once the slot frees.
// Any valid register write restarts the pool.
module fixed_chunk_pool_allocator_core
    import fcpa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [ADDR_W-1:0]    i_chunk_address,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [COUNT_W-1:0]   o_free_total,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    localparam int PTR_W  = $clog2(POOL_DEPTH);
    localparam int FILL_W = $clog2(POOL_DEPTH + 1);
    localparam int SUM_W  = ((FILL_W > COUNT_W) ? FILL_W : COUNT_W) + 1;

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(POOL_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(POOL_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_chunk_count, n_chunk_count;
    logic [BYTES_W-1:0]  r_chunk_bytes, n_chunk_bytes;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [COUNT_W-1:0]  r_fresh_handed, n_fresh_handed;
    logic [ADDR_W-1:0]   r_next_fresh, n_next_fresh;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_granted, n_granted;
    logic [COUNT_W-1:0]  r_free_total, n_free_total;

    logic              out_free;
    logic              in_accept;
    logic              cfg_hit;
    logic              fresh_avail;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_data;
    logic [COUNT_W-1:0] fresh_left;
    logic [SUM_W-1:0]  total_sum;

    fcpa_queue_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (ADDR_W)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_chunk_address),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && ((i_cfg_index == CFG_CHUNK_COUNT)
                         || (i_cfg_index == CFG_CHUNK_BYTES)
                         || (i_cfg_index == CFG_BASE_ADDRESS));
    assign fresh_avail = r_fresh_handed < r_chunk_count;

    assign wr_en = in_accept && !cfg_hit && (i_op == OP_FREE) && (r_fill != FILL_MAX);
    assign rd_en = in_accept && !cfg_hit && (i_op == OP_ALLOC) && !fresh_avail
                   && (r_fill != '0);

    // free total from the post-item state
    assign fresh_left = (n_fresh_handed < n_chunk_count) ? (n_chunk_count - n_fresh_handed)
                                                         : '0;
    assign total_sum  = SUM_W'(fresh_left) + SUM_W'(n_fill);

    always_comb begin
        n_state        = r_state;
        n_chunk_count  = r_chunk_count;
        n_chunk_bytes  = r_chunk_bytes;
        n_base         = r_base;
        n_head         = r_head;
        n_tail         = r_tail;
        n_fill         = r_fill;
        n_fresh_handed = r_fresh_handed;
        n_next_fresh   = r_next_fresh;
        n_out_valid    = r_out_valid && i_out_stall;
        n_status       = r_status;
        n_granted      = r_granted;

        if (cfg_hit) begin
            unique case (i_cfg_index)
                CFG_CHUNK_COUNT:  n_chunk_count = i_cfg_data[COUNT_W-1:0];
                CFG_CHUNK_BYTES:  n_chunk_bytes = i_cfg_data[BYTES_W-1:0];
                default:          n_base        = i_cfg_data;
            endcase
            n_head         = '0;
            n_tail         = '0;
            n_fill         = '0;
            n_fresh_handed = '0;
            n_next_fresh   = (i_cfg_index == CFG_BASE_ADDRESS) ? i_cfg_data : r_base;
            n_state        = S_IDLE;
        end else if (r_state == S_READ) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_status    = STATUS_OK;
                n_granted   = rd_data;
                n_state     = S_IDLE;
            end
        end else if (in_accept) begin
            n_status  = STATUS_OK;
            n_granted = '0;
            if (i_op == OP_ALLOC) begin
                priority if (fresh_avail) begin
                    n_granted      = r_next_fresh;
                    n_next_fresh   = r_next_fresh + ADDR_W'(r_chunk_bytes);
                    n_fresh_handed = r_fresh_handed + COUNT_W'(1);
                    n_out_valid    = 1'b1;
                end else if (r_fill != '0) begin
                    n_head  = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                    n_fill  = r_fill - FILL_W'(1);
                    n_state = S_READ;
                end else begin
                    n_status    = STATUS_EMPTY;
                    n_out_valid = 1'b1;
                end
            end else begin
                if (r_fill != FILL_MAX) begin
                    n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                    n_fill = r_fill + FILL_W'(1);
                end else begin
                    n_status = STATUS_FULL;
                end
                n_out_valid = 1'b1;
            end
        end

        n_free_total = r_free_total;
        if (n_out_valid && !(r_out_valid && i_out_stall)) begin
            n_free_total = (total_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : total_sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_chunk_count  <= RST_CHUNK_COUNT;
            r_chunk_bytes  <= RST_CHUNK_BYTES;
            r_base         <= RST_BASE_ADDRESS;
            r_head         <= '0;
            r_tail         <= '0;
            r_fill         <= '0;
            r_fresh_handed <= '0;
            r_next_fresh   <= RST_BASE_ADDRESS;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_chunk_count  <= n_chunk_count;
            r_chunk_bytes  <= n_chunk_bytes;
            r_base         <= n_base;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_fill         <= n_fill;
            r_fresh_handed <= n_fresh_handed;
            r_next_fresh   <= n_next_fresh;
            r_out_valid    <= n_out_valid;
        end
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_free_total <= n_free_total;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_free_total      = r_free_total;

endmodule
